// ===== rtl/core/rwwc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwwc_pkg: shared types and constants of the record/word width counter
// Byte classes, queue and window entry types, register map and field widths.
// ----------------------------------------------------------------------------
package rwwc_pkg;

	localparam int OUT_COUNT_W = 40;
	localparam int OUT_COL_W   = 32;
	localparam int COL_W       = 32;
	localparam int LEN_REG_W   = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_ADDR_W-1:0] ADDR_DELIM_LENGTH = 4'h0;
	localparam logic [CFG_ADDR_W-1:0] ADDR_DELIM_BYTES  = 4'h8;

	localparam logic [LEN_REG_W-1:0]  DELIM_LENGTH_RESET = 4'd1;
	localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RESET  = 64'd10;

	typedef enum logic [2:0] {
		CLS_BREAK,
		CLS_TAB,
		CLS_SPACE,
		CLS_VTAB,
		CLS_PRINT,
		CLS_OTHER
	} byte_class_t;

	typedef struct packed {
		logic        is_end;
		logic [7:0]  data;
		byte_class_t cls;
	} queue_entry_t;

	typedef struct packed {
		logic         valid;
		queue_entry_t entry;
	} queue_xfer_t;

	typedef struct packed {
		logic [7:0]  data;
		byte_class_t cls;
	} win_entry_t;

	typedef struct packed {
		logic [LEN_REG_W-1:0]  length;
		logic [CFG_DATA_W-1:0] bytes;
	} cfg_t;

endpackage

// ===== rtl/core/rwwc_if.sv =====
// ----------------------------------------------------------------------------
// rwwc_if: item and result channels of the record/word width counter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rwwc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface rwwc_out_if;
	logic                               valid;
	logic                               ready;
	logic [rwwc_pkg::OUT_COUNT_W-1:0]   total_records;
	logic [rwwc_pkg::OUT_COUNT_W-1:0]   word_total;
	logic [rwwc_pkg::OUT_COUNT_W-1:0]   byte_total;
	logic [rwwc_pkg::OUT_COL_W-1:0]     widest_record;

	modport source (output valid, output total_records, output word_total,
		output byte_total, output widest_record, input ready);
	modport sink (input valid, input total_records, input word_total,
		input byte_total, input widest_record, output ready);
endinterface

// ===== rtl/core/rwwc_regs.sv =====
// ----------------------------------------------------------------------------
// rwwc_regs: configuration registers
// APB-style register file holding the delimiter length and delimiter bytes.
// ----------------------------------------------------------------------------
module rwwc_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rwwc_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [rwwc_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [rwwc_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output rwwc_pkg::cfg_t                      cfg
);

	logic [rwwc_pkg::LEN_REG_W-1:0]  length_q;
	logic [rwwc_pkg::CFG_DATA_W-1:0] bytes_q;
	logic                            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= rwwc_pkg::DELIM_LENGTH_RESET;
			bytes_q  <= rwwc_pkg::DELIM_BYTES_RESET;
		end else if (wr_en) begin
			unique case (paddr)
				rwwc_pkg::ADDR_DELIM_LENGTH: begin
					length_q <= pwdata[rwwc_pkg::LEN_REG_W-1:0];
				end
				rwwc_pkg::ADDR_DELIM_BYTES: begin
					bytes_q <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			rwwc_pkg::ADDR_DELIM_LENGTH: prdata = rwwc_pkg::CFG_DATA_W'(length_q);
			rwwc_pkg::ADDR_DELIM_BYTES:  prdata = bytes_q;
			default:                     prdata = '0;
		endcase
	end

	assign cfg.length = length_q;
	assign cfg.bytes  = bytes_q;

endmodule

// ===== rtl/core/rwwc_front.sv =====
// ----------------------------------------------------------------------------
// rwwc_front: item intake and byte classification
// Accepts items and tags each data byte with its character class.
// ----------------------------------------------------------------------------
module rwwc_front (
	rwwc_in_if.sink                 item,
	output rwwc_pkg::queue_xfer_t   push,
	input  logic                    push_ready
);

	localparam logic [7:0] CHR_TAB      = 8'h09;
	localparam logic [7:0] CHR_LF       = 8'h0A;
	localparam logic [7:0] CHR_VT       = 8'h0B;
	localparam logic [7:0] CHR_FF       = 8'h0C;
	localparam logic [7:0] CHR_CR       = 8'h0D;
	localparam logic [7:0] CHR_SPACE    = 8'h20;
	localparam logic [7:0] CHR_PRINT_HI = 8'h7E;

	rwwc_pkg::byte_class_t cls;

	always_comb begin
		priority if (item.data_byte == CHR_CR || item.data_byte == CHR_FF ||
				item.data_byte == CHR_LF) begin
			cls = rwwc_pkg::CLS_BREAK;
		end else if (item.data_byte == CHR_TAB) begin
			cls = rwwc_pkg::CLS_TAB;
		end else if (item.data_byte == CHR_SPACE) begin
			cls = rwwc_pkg::CLS_SPACE;
		end else if (item.data_byte == CHR_VT) begin
			cls = rwwc_pkg::CLS_VTAB;
		end else if (item.data_byte > CHR_SPACE && item.data_byte <= CHR_PRINT_HI) begin
			cls = rwwc_pkg::CLS_PRINT;
		end else begin
			cls = rwwc_pkg::CLS_OTHER;
		end
	end

	assign item.ready        = push_ready;
	assign push.valid        = item.valid;
	assign push.entry.is_end = item.mode;
	assign push.entry.data   = item.data_byte;
	assign push.entry.cls    = cls;

endmodule

// ===== rtl/core/rwwc_queue.sv =====
// ----------------------------------------------------------------------------
// rwwc_queue: decoupling queue between front and back end
// Small register FIFO of classified items.
// ----------------------------------------------------------------------------
module rwwc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rwwc_pkg::queue_xfer_t   push,
	output logic                    push_ready,
	output rwwc_pkg::queue_xfer_t   head,
	input  logic                    pop
);

	localparam int DEPTH = rwwc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	rwwc_pkg::queue_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (fill_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + FILL_W'(do_push) - FILL_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	assign head.valid = (fill_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

endmodule

// ===== rtl/core/rwwc_back.sv =====
// ----------------------------------------------------------------------------
// rwwc_back: delimiter window, counters and result register
// Matches the held window against the delimiter, releases text bytes into
// the word and column counters, and registers the totals at end of stream.
// ----------------------------------------------------------------------------
module rwwc_back #(
	parameter int DELIM_MAX  = 8,
	parameter int COUNT_BITS = 40,
	parameter int TAB_STOP   = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rwwc_pkg::cfg_t          cfg,
	input  rwwc_pkg::queue_xfer_t   head,
	output logic                    pop,
	rwwc_out_if.source              result
);

	localparam int CNT_W = $clog2(DELIM_MAX + 1);
	localparam int IDX_W = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
	localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam int DX_W  = 8 * DELIM_MAX;
	localparam int CW    = rwwc_pkg::COL_W;
	localparam logic [PH_W-1:0] COL_MAX_PHASE = PH_W'(32'hFFFF_FFFF % TAB_STOP);

	rwwc_pkg::win_entry_t   win_q [DELIM_MAX];
	rwwc_pkg::win_entry_t   wv    [DELIM_MAX];
	rwwc_pkg::win_entry_t   win_d [DELIM_MAX];
	rwwc_pkg::win_entry_t   rel;
	logic [CNT_W-1:0]       count_q, count_d, wcount, act_len, drop;
	logic [CNT_W:0]         shift_src;
	logic [DX_W-1:0]        delim_ext;
	logic [COUNT_BITS-1:0]  rec_q, rec_d, word_q, word_d, byte_q, byte_d;
	logic [CW-1:0]          col_q, col_d, widest_q, widest_d, col_peak;
	logic [PH_W-1:0]        phase_q, phase_d, inc_phase;
	logic                   inword_q, inword_d;
	logic [CW:0]            inc_sum, tab_sum;
	logic                   head_data, head_end, rescan, take_byte, flush, finish;
	logic                   iterate, hit, match, release_byte;
	logic                   out_valid_q;
	logic [rwwc_pkg::OUT_COUNT_W-1:0] out_rec_q, out_word_q, out_byte_q;
	logic [rwwc_pkg::OUT_COL_W-1:0]   out_widest_q;

	always_comb begin
		if (cfg.length == '0) begin
			act_len = CNT_W'(1);
		end else if (int'(cfg.length) > DELIM_MAX) begin
			act_len = CNT_W'(DELIM_MAX);
		end else begin
			act_len = CNT_W'(cfg.length);
		end
	end

	assign delim_ext = DX_W'(cfg.bytes);

	assign head_data = head.valid && !head.entry.is_end;
	assign head_end  = head.valid && head.entry.is_end;
	assign rescan    = head_data && (count_q >= act_len);
	assign take_byte = head_data && !rescan;
	assign flush     = head_end && (count_q != '0);
	assign finish    = head_end && (count_q == '0) && (!out_valid_q || result.ready);
	assign pop       = take_byte || finish;

	always_comb begin
		for (int i = 0; i < DELIM_MAX; i++) begin
			wv[i] = win_q[i];
			if (take_byte && (count_q == CNT_W'(i))) begin
				wv[i].data = head.entry.data;
				wv[i].cls  = head.entry.cls;
			end
		end
	end

	assign wcount = count_q + CNT_W'(take_byte);
	assign iterate = (rescan || take_byte) && (wcount >= act_len);

	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < DELIM_MAX; i++) begin
			if ((CNT_W'(i) < act_len) && (wv[i].data != delim_ext[8*i +: 8])) begin
				hit = 1'b0;
			end
		end
	end

	assign match        = iterate && hit;
	assign release_byte = (iterate && !hit) || flush;
	assign rel          = wv[0];

	always_comb begin
		if (match) begin
			drop = act_len;
		end else if (release_byte) begin
			drop = CNT_W'(1);
		end else begin
			drop = '0;
		end
	end

	always_comb begin
		shift_src = '0;
		for (int i = 0; i < DELIM_MAX; i++) begin
			shift_src = (CNT_W + 1)'(i) + {1'b0, drop};
			win_d[i] = wv[i];
			if (shift_src < (CNT_W + 1)'(DELIM_MAX)) begin
				win_d[i] = wv[shift_src[IDX_W-1:0]];
			end
		end
	end

	assign count_d = finish ? '0 : (wcount - drop);

	assign col_peak  = (col_q > widest_q) ? col_q : widest_q;
	assign inc_sum   = {1'b0, col_q} + (CW + 1)'(1);
	assign tab_sum   = {1'b0, col_q} + (CW + 1)'(TAB_STOP) - (CW + 1)'(phase_q);
	assign inc_phase = (phase_q == PH_W'(TAB_STOP - 1)) ? '0 : phase_q + PH_W'(1);

	always_comb begin
		rec_d    = rec_q;
		word_d   = word_q;
		byte_d   = byte_q;
		col_d    = col_q;
		phase_d  = phase_q;
		widest_d = widest_q;
		inword_d = inword_q;
		if (take_byte && (byte_q != '1)) begin
			byte_d = byte_q + COUNT_BITS'(1);
		end
		if (match) begin
			if (rec_q != '1) begin
				rec_d = rec_q + COUNT_BITS'(1);
			end
			widest_d = col_peak;
			col_d    = '0;
			phase_d  = '0;
			inword_d = 1'b0;
		end else if (release_byte) begin
			unique case (rel.cls)
				rwwc_pkg::CLS_BREAK: begin
					widest_d = col_peak;
					col_d    = '0;
					phase_d  = '0;
					inword_d = 1'b0;
				end
				rwwc_pkg::CLS_TAB: begin
					col_d    = tab_sum[CW] ? '1 : tab_sum[CW-1:0];
					phase_d  = tab_sum[CW] ? COL_MAX_PHASE : '0;
					inword_d = 1'b0;
				end
				rwwc_pkg::CLS_SPACE: begin
					col_d    = inc_sum[CW] ? '1 : inc_sum[CW-1:0];
					phase_d  = inc_sum[CW] ? COL_MAX_PHASE : inc_phase;
					inword_d = 1'b0;
				end
				rwwc_pkg::CLS_VTAB: begin
					inword_d = 1'b0;
				end
				rwwc_pkg::CLS_PRINT: begin
					col_d   = inc_sum[CW] ? '1 : inc_sum[CW-1:0];
					phase_d = inc_sum[CW] ? COL_MAX_PHASE : inc_phase;
					if (!inword_q && (word_q != '1)) begin
						word_d = word_q + COUNT_BITS'(1);
					end
					inword_d = 1'b1;
				end
				rwwc_pkg::CLS_OTHER: begin
					if (!inword_q && (word_q != '1)) begin
						word_d = word_q + COUNT_BITS'(1);
					end
					inword_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (finish) begin
			rec_d    = '0;
			word_d   = '0;
			byte_d   = '0;
			col_d    = '0;
			phase_d  = '0;
			widest_d = '0;
			inword_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rec_q       <= '0;
			word_q      <= '0;
			byte_q      <= '0;
			col_q       <= '0;
			phase_q     <= '0;
			widest_q    <= '0;
			inword_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			rec_q    <= rec_d;
			word_q   <= word_d;
			byte_q   <= byte_d;
			col_q    <= col_d;
			phase_q  <= phase_d;
			widest_q <= widest_d;
			inword_q <= inword_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DELIM_MAX; i++) begin
			win_q[i] <= win_d[i];
		end
		if (finish) begin
			out_rec_q    <= rwwc_pkg::OUT_COUNT_W'(rec_q);
			out_word_q   <= rwwc_pkg::OUT_COUNT_W'(word_q);
			out_byte_q   <= rwwc_pkg::OUT_COUNT_W'(byte_q);
			out_widest_q <= col_peak;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.total_records = out_rec_q;
	assign result.word_total    = out_word_q;
	assign result.byte_total    = out_byte_q;
	assign result.widest_record = out_widest_q;

endmodule

// ===== rtl/core/record_word_width_counter.sv =====
// ----------------------------------------------------------------------------
// record_word_width_counter: record, word, byte and widest-record counter
// Data bytes: one transfer per cycle while the window is not being flushed
// or rescanned and no end item waits on the result; each byte is counted,
// compared against the delimiter window and later released into the word
// and column counters. End item: bytes still held in the window (at most
// DELIM_MAX-1) are flushed first, then the totals are registered. Once the
// delimiter length shrinks, held bytes beyond it are rescanned out first.
// Reset clears the queue, window, counters and result; delimiter = LF.
// ----------------------------------------------------------------------------
module record_word_width_counter #(
	parameter int DELIM_MAX  = 8,
	parameter int COUNT_BITS = 40,
	parameter int TAB_STOP   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rwwc_in_if.sink                             item,
	rwwc_out_if.source                          result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rwwc_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [rwwc_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [rwwc_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);

	rwwc_pkg::cfg_t        cfg;
	rwwc_pkg::queue_xfer_t push;
	rwwc_pkg::queue_xfer_t head;
	logic                  push_ready;
	logic                  pop;

	rwwc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rwwc_front u_front (
		.item       (item),
		.push       (push),
		.push_ready (push_ready)
	);

	rwwc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	rwwc_back #(
		.DELIM_MAX  (DELIM_MAX),
		.COUNT_BITS (COUNT_BITS),
		.TAB_STOP   (TAB_STOP)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== rtl/core/rwwc_checker.sv =====
// ----------------------------------------------------------------------------
// rwwc_checker: port-level checks of the record/word width counter
// Watches item and result transfers and checks result consistency.
// ----------------------------------------------------------------------------
module rwwc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 in_mode,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [rwwc_pkg::OUT_COUNT_W-1:0]     total_records,
	input logic [rwwc_pkg::OUT_COUNT_W-1:0]     word_total,
	input logic [rwwc_pkg::OUT_COUNT_W-1:0]     byte_total
);

	logic [3:0] pend_q;
	logic       end_in;
	logic       res_out;

	assign end_in  = in_valid && in_ready && in_mode;
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(end_in) - 4'(res_out);
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before its transfer");

	a_result_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("result offered without an outstanding end item");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total_records <= byte_total) && (word_total <= byte_total))
		else $error("record or word total exceeds byte total");

endmodule

bind record_word_width_counter rwwc_checker u_rwwc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.in_mode       (item.mode),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.total_records (result.total_records),
	.word_total    (result.word_total),
	.byte_total    (result.byte_total)
);
